/* rtl/assert_macros.svh */
// Assertion macros shared by the nearest obstacle locator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition implies another one on the next edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/sno_pkg.sv */
// Shared types, constants and tables of the nearest obstacle locator.
`default_nettype none

package sno_pkg;

  // Defaults for the top level parameters
  localparam int SCAN_LENGTH_DEF  = 4096;
  localparam int CORDIC_STEPS_DEF = 20;

  // Field widths
  localparam int RANGE_W    = 19;
  localparam int DIST_W     = 20;
  localparam int ANG_W      = 24;
  localparam int STEP_W     = 21;
  localparam int POS_W      = 20;
  localparam int IDX_MAX_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [RANGE_W-1:0]       MAX_RANGE_RST   = 19'd30000;
  localparam logic signed [ANG_W-1:0]  START_ANGLE_RST = -24'sd3294199;
  localparam logic [STEP_W-1:0]        ANGLE_STEP_RST  = 21'd1830;

  // Marker for a scan without a valid sample
  localparam logic signed [DIST_W-1:0] NONE_MM = -20'sd100000;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RANGE   = 2'd0,
    REG_START_ANGLE = 2'd1,
    REG_ANGLE_STEP  = 2'd2
  } cfg_reg_t;

  // Best sample of a finished scan
  typedef struct packed {
    logic                 found;
    logic [RANGE_W-1:0]   range;
    logic [IDX_MAX_W-1:0] index;
  } scan_res_t;

  // One result beat
  typedef struct packed {
    logic                     found;
    logic signed [DIST_W-1:0] distance;
    logic signed [ANG_W-1:0]  angle;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } out_item_t;

  // Arctangent of 2^-k in units of 2^-30 rad
  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    unique case (k)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/sno_track.sv */
// Per-sample validity check and running minimum of one scan.
`default_nettype none

`include "assert_macros.svh"

module sno_track #(
  parameter int SCAN_LENGTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic signed [sno_pkg::DIST_W-1:0] range_mm,
  input  wire logic                           not_finite,
  input  wire logic                           last_sample,
  input  wire logic [sno_pkg::RANGE_W-1:0]    max_range_mm,
  output sno_pkg::scan_res_t                  scan_res
);
  import sno_pkg::*;

  localparam int CNT_W = $clog2(SCAN_LENGTH + 1);
  localparam int IDX_W = (SCAN_LENGTH > 1) ? $clog2(SCAN_LENGTH) : 1;

  logic [CNT_W-1:0]   sample_count;
  logic [RANGE_W-1:0] best_range;
  logic [IDX_W-1:0]   best_index;
  logic               any_valid;

  logic               in_window;
  logic               sample_ok;
  logic               take;

  // Qualify the sample and compare against the running minimum
  assign in_window = sample_count < CNT_W'(SCAN_LENGTH);
  assign sample_ok = !not_finite && !range_mm[DIST_W-1] &&
                     (range_mm[RANGE_W-1:0] <= max_range_mm);
  assign take      = in_window && sample_ok &&
                     (!any_valid || (range_mm[RANGE_W-1:0] < best_range));

  // Scan summary including the sample at the port
  always_comb begin
    scan_res.found = any_valid | take;
    scan_res.range = take ? range_mm[RANGE_W-1:0] : best_range;
    scan_res.index = take ? IDX_MAX_W'(sample_count[IDX_W-1:0])
                          : IDX_MAX_W'(best_index);
  end

  // Update the scan state; clear it after the last beat
  always_ff @(posedge clk) begin
    if (rst || (accept && last_sample)) begin
      sample_count <= '0;
      best_range   <= '1;
      best_index   <= '0;
      any_valid    <= 1'b0;
    end else if (accept && in_window) begin
      sample_count <= sample_count + CNT_W'(1);
      if (take) begin
        best_range <= range_mm[RANGE_W-1:0];
        best_index <= sample_count[IDX_W-1:0];
        any_valid  <= 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, sample_count <= CNT_W'(SCAN_LENGTH))
  `ASSERT_CLK(a_empty_scan, clk, rst, any_valid || (best_range == '1 && best_index == '0))

endmodule

`default_nettype wire

/* rtl/sno_solver.sv */
// Sequencer with one shared multiplier and an iterative CORDIC rotator.
`default_nettype none

`include "assert_macros.svh"

module sno_solver #(
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  sno_pkg::scan_res_t                 scan_res,
  input  wire logic signed [sno_pkg::ANG_W-1:0] start_angle,
  input  wire logic [sno_pkg::STEP_W-1:0]    angle_step,
  input  wire logic                          out_free,
  output logic                               idle,
  output logic                               res_valid,
  output sno_pkg::out_item_t                 res
);
  import sno_pkg::*;

  localparam int ITER_W  = $clog2(CORDIC_STEPS + 1);
  localparam int Z_W     = 35;
  localparam int XY_W    = 33;
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 34;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 39;

  localparam logic signed [Z_W-1:0]   PI_Q30      = 35'sd3373259426;
  localparam logic signed [Z_W-1:0]   NEG_PI_Q30  = -35'sd3373259426;
  localparam logic signed [Z_W-1:0]   TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [Z_W-1:0]   NEG_HALF_PI = -35'sd1686629713;
  localparam logic signed [XY_W-1:0]  GAIN_Q30    = 33'sd652032875;
  localparam logic signed [SUM_W-1:0] ANG_HI      = 39'sd8388607;
  localparam logic signed [SUM_W-1:0] ANG_LO      = -39'sd8388608;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 54'sd536870912;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ANG_MUL = 9'b000000010,
    S_ANG_SUM = 9'b000000100,
    S_WRAP    = 9'b000001000,
    S_HALF    = 9'b000010000,
    S_ITER    = 9'b000100000,
    S_MUL_X   = 9'b001000000,
    S_MUL_Y   = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic                      found_q;
  logic [RANGE_W-1:0]        dist_q;
  logic [IDX_MAX_W-1:0]      idx_q;
  logic signed [ANG_W-1:0]   ang_q;
  logic signed [Z_W-1:0]     z;
  logic signed [XY_W-1:0]    x;
  logic signed [XY_W-1:0]    y;
  logic                      flip;
  logic [ITER_W-1:0]         iter;
  logic signed [PROD_W-1:0]  prod;
  logic signed [POS_W-1:0]   px_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MUL_A_W-1:0] d_pos;
  logic signed [SUM_W-1:0]   ang_sum;
  logic signed [ANG_W-1:0]   ang_sat;
  logic signed [XY_W-1:0]    x_sh;
  logic signed [XY_W-1:0]    y_sh;
  logic signed [Z_W-1:0]     atan_z;
  logic                      last_iter;

  // Round to nearest mm and clamp to the position range
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-31:0] q;
    logic signed [POS_W-1:0]  r;
    s = p + ROUND_HALF;
    q = s[PROD_W-1:30];
    if (q > (PROD_W-30)'(524287)) begin
      r = 20'sd524287;
    end else if (q < -(PROD_W-30)'(524288)) begin
      r = -20'sd524288;
    end else begin
      r = q[POS_W-1:0];
    end
    return r;
  endfunction

  // Shared multiplier operand select
  assign d_pos = signed'({1'b0, dist_q});
  always_comb begin
    unique case (state)
      S_ANG_MUL: begin
        mul_a = signed'(MUL_A_W'(idx_q));
        mul_b = signed'(MUL_B_W'(angle_step));
      end
      S_MUL_X: begin
        mul_a = flip ? -d_pos : d_pos;
        mul_b = MUL_B_W'(x);
      end
      S_MUL_Y: begin
        mul_a = flip ? -d_pos : d_pos;
        mul_b = MUL_B_W'(y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Angle sum from the registered product, saturated
  assign ang_sum = SUM_W'(start_angle) + signed'(prod[SUM_W-1:0]);
  always_comb begin
    if (ang_sum > ANG_HI) begin
      ang_sat = 24'sd8388607;
    end else if (ang_sum < ANG_LO) begin
      ang_sat = -24'sd8388608;
    end else begin
      ang_sat = ang_sum[ANG_W-1:0];
    end
  end

  // CORDIC micro-rotation terms
  assign x_sh      = x >>> iter;
  assign y_sh      = y >>> iter;
  assign atan_z    = signed'({3'b000, atan_q30(5'(iter))});
  assign last_iter = iter == ITER_W'(CORDIC_STEPS - 1);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = scan_res.found ? S_ANG_MUL : S_FIN;
      S_ANG_MUL: state_next = S_ANG_SUM;
      S_ANG_SUM: state_next = S_WRAP;
      S_WRAP:    state_next = S_HALF;
      S_HALF:    state_next = S_ITER;
      S_ITER:    if (last_iter) state_next = S_MUL_X;
      S_MUL_X:   state_next = S_MUL_Y;
      S_MUL_Y:   state_next = S_FIN;
      S_FIN:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          found_q <= scan_res.found;
          dist_q  <= scan_res.range;
          idx_q   <= scan_res.index;
        end
      end
      S_ANG_MUL: prod <= mul_p;
      S_ANG_SUM: begin
        ang_q <= ang_sat;
        z     <= signed'({{(Z_W-ANG_W-10){ang_sat[ANG_W-1]}}, ang_sat, 10'b0});
      end
      S_WRAP: begin
        if (z > PI_Q30) begin
          z <= z - TWO_PI_Q30;
        end else if (z < NEG_PI_Q30) begin
          z <= z + TWO_PI_Q30;
        end
      end
      S_HALF: begin
        if (z > HALF_PI_Q30) begin
          z    <= z - PI_Q30;
          flip <= 1'b1;
        end else if (z < NEG_HALF_PI) begin
          z    <= z + PI_Q30;
          flip <= 1'b1;
        end else begin
          flip <= 1'b0;
        end
        x    <= GAIN_Q30;
        y    <= '0;
        iter <= '0;
      end
      S_ITER: begin
        if (!z[Z_W-1]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_z;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_z;
        end
        iter <= iter + ITER_W'(1);
      end
      S_MUL_X: prod <= mul_p;
      S_MUL_Y: begin
        px_q <= round_sat(prod);
        prod <= mul_p;
      end
      default: ;
    endcase
  end

  // Result beat
  assign idle      = state == S_IDLE;
  assign res_valid = (state == S_FIN) && out_free;
  always_comb begin
    if (found_q) begin
      res.found    = 1'b1;
      res.distance = signed'({1'b0, dist_q});
      res.angle    = ang_q;
      res.pos_x    = px_q;
      res.pos_y    = round_sat(prod);
    end else begin
      res.found    = 1'b0;
      res.distance = NONE_MM;
      res.angle    = '0;
      res.pos_x    = NONE_MM;
      res.pos_y    = '0;
    end
  end

  `ASSERT_CLK(a_start_idle, clk, rst, !start || state == S_IDLE)
  `ASSERT_CLK(a_iter_bound, clk, rst, state != S_ITER || iter < ITER_W'(CORDIC_STEPS))
  `ASSERT_NEXT(a_fin_hold, clk, rst, state == S_FIN && !out_free, state == S_FIN)

endmodule

`default_nettype wire

/* rtl/scan_nearest_obstacle_locator.sv */
// Top level of the nearest obstacle locator: ports, registers, result buffer.
//
//  channel  dir  handshake                   contents
//  s_axis   in   s_axis_tvalid/s_axis_tready range sample, invalid flag, last mark
//  m_axis   out  m_axis_tvalid/m_axis_tready one result per scan
//  cfg      in   cfg_valid/cfg_ready         register index and data
//
// A sample that does not end a scan leaves s_axis_tready high. The last sample
// of a scan with a valid point keeps s_axis_tready low while the shared
// multiplier forms the angle, two folds bring it into range, the CORDIC runs
// one rotation a cycle, and the same multiplier scales x and y. A scan without
// a valid point goes straight to the last step. A result stalled on m_axis holds
// the sequencer in its last step; samples are taken again once it is buffered.
// Reset is synchronous and restores the register defaults and an empty scan.
`default_nettype none

`include "assert_macros.svh"

module scan_nearest_obstacle_locator #(
  parameter int SCAN_LENGTH  = sno_pkg::SCAN_LENGTH_DEF,
  parameter int CORDIC_STEPS = sno_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [23:0]                       s_axis_tdata,  // range_mm[19:0]
  input  wire logic [0:0]                        s_axis_tuser,  // not_finite
  input  wire logic                              s_axis_tlast,  // last_sample
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // min_distance_mm[19:0], obstacle_angle[43:20], pos_x_mm[63:44], pos_y_mm[83:64]
  output logic [87:0]                            m_axis_tdata,
  output logic [0:0]                             m_axis_tuser,  // found
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sno_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sno_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sno_pkg::*;

  logic [RANGE_W-1:0]       max_range_mm;
  logic signed [ANG_W-1:0]  start_angle;
  logic [STEP_W-1:0]        angle_step;

  logic                     in_accept;
  logic                     scan_start;
  scan_res_t                scan_res;
  logic                     solver_idle;
  logic                     res_valid;
  out_item_t                res;
  out_item_t                out_q;
  logic                     out_free;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_range_mm <= MAX_RANGE_RST;
      start_angle  <= START_ANGLE_RST;
      angle_step   <= ANGLE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RANGE:   max_range_mm <= cfg_data[RANGE_W-1:0];
        REG_START_ANGLE: start_angle  <= signed'(cfg_data[ANG_W-1:0]);
        REG_ANGLE_STEP:  angle_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat acceptance
  assign s_axis_tready = solver_idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign scan_start    = in_accept && s_axis_tlast;

  sno_track #(
    .SCAN_LENGTH (SCAN_LENGTH)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .range_mm     (signed'(s_axis_tdata[DIST_W-1:0])),
    .not_finite   (s_axis_tuser[0]),
    .last_sample  (s_axis_tlast),
    .max_range_mm (max_range_mm),
    .scan_res     (scan_res)
  );

  sno_solver #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_solver (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .scan_res    (scan_res),
    .start_angle (start_angle),
    .angle_step  (angle_step),
    .out_free    (out_free),
    .idle        (solver_idle),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output buffer: hold the result beat until taken
  assign out_free = !m_axis_tvalid || m_axis_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {4'b0000, out_q.pos_y, out_q.pos_x, out_q.angle, out_q.distance};
  assign m_axis_tuser = out_q.found;

  `ASSERT_NEXT(a_last_busy, clk, rst, scan_start, !s_axis_tready)
  `ASSERT_CLK(a_res_room, clk, rst, !res_valid || out_free)

endmodule

`default_nettype wire

/* test/scan_nearest_obstacle_locator_tb.sv */
// Self-checking testbench for the nearest obstacle locator: random scans against a predictor.
`timescale 1ns / 100ps

module scan_nearest_obstacle_locator_tb;
  import sno_pkg::*;

  localparam int SCAN_LEN     = SCAN_LENGTH_DEF;
  localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032875;
  localparam longint ROUND_Q30   = 64'sd536870912;
  // Index past the register file; a write to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [19:0] rng;
    logic               bad;
    logic               last;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // range_mm[19:0]
  logic [0:0]            s_axis_tuser = '0;  // not_finite
  logic                  s_axis_tlast = 1'b0;  // last_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // min_distance_mm[19:0], obstacle_angle[43:20], pos_x_mm[63:44], pos_y_mm[83:64]
  logic [87:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;  // found
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register mirror
  logic [18:0]        cfg_max_mm = MAX_RANGE_RST;
  logic signed [23:0] cfg_start  = START_ANGLE_RST;
  logic [20:0]        cfg_step   = ANGLE_STEP_RST;

  // Scan state of the predictor
  int          scan_pos   = 0;
  logic [18:0] best_mm    = 19'h7FFFF;
  int          best_pos   = 0;
  bit          seen_valid = 1'b0;

  sample_t   sample_q[$];
  out_item_t pending_fixes[$];
  sample_t   drive_item;
  bit        in_fire    = 1'b0;
  bit        idle_on    = 1'b1;
  bit        hold_req   = 1'b0;
  int        hold_left  = 0;
  int        gap_left   = 0;
  int        stall_left = 0;
  int        fails      = 0;

  scan_nearest_obstacle_locator #(
    .SCAN_LENGTH (SCAN_LEN),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Arctangent of 2^-k, 2^-30 rad
  function automatic longint arctan_q30(input int k);
    case (k)
      0:  return 64'h3243F6A8;
      1:  return 64'h1DAC6705;
      2:  return 64'h0FADBAFC;
      3:  return 64'h07F56EA6;
      4:  return 64'h03FEAB76;
      5:  return 64'h01FFD55B;
      6:  return 64'h00FFFAAA;
      7:  return 64'h007FFF55;
      8:  return 64'h003FFFEA;
      9:  return 64'h001FFFFD;
      10: return 64'h000FFFFF;
      11: return 64'h0007FFFF;
      12: return 64'h0003FFFF;
      13: return 64'h0001FFFF;
      14: return 64'h0000FFFF;
      15: return 64'h00007FFF;
      16: return 64'h00003FFF;
      17: return 64'h00001FFF;
      18: return 64'h00000FFF;
      19: return 64'h000007FF;
      20: return 64'h000003FF;
      21: return 64'h000001FF;
      22: return 64'h000000FF;
      23: return 64'h0000007F;
      24: return 64'h0000003F;
      25: return 64'h0000001F;
      26: return 64'h0000000F;
      27: return 64'h00000008;
      28: return 64'h00000004;
      29: return 64'h00000002;
      30: return 64'h00000001;
      default: return 64'h0;
    endcase
  endfunction

  // Cosine and sine of a 2^-20 rad angle, Q30, by rotation from (K, 0)
  function automatic void unit_rotation(input longint ang, output longint c,
                                        output longint s);
    longint z, x, y, t;
    bit     flip;
    int     k;
    z = ang * 1024;
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    while (z > PI_Q30) z -= 2 * PI_Q30;
    while (z < -PI_Q30) z += 2 * PI_Q30;
    // fold into the right half plane and negate the result
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin
      if (z >= 0) begin
        t = x - (y >>> (k % 32));
        y = y + (x >>> (k % 32));
        z -= arctan_q30(k % 32);
      end else begin
        t = x + (y >>> (k % 32));
        y = y - (x >>> (k % 32));
        z += arctan_q30(k % 32);
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Fold one accepted sample into the scan; queue the fix on the last one
  task automatic absorb_sample(input logic signed [19:0] rng, input logic bad,
                               input logic last);
    out_item_t fix;
    longint    ang, c, s, px, py;
    if (scan_pos < SCAN_LEN) begin
      if (!bad && longint'(rng) >= 0 && longint'(rng) <= longint'(cfg_max_mm)) begin
        if (!seen_valid || rng[18:0] < best_mm) begin
          best_mm    = rng[18:0];
          best_pos   = scan_pos;
          seen_valid = 1'b1;
        end
      end
      scan_pos++;
    end
    if (last) begin
      if (seen_valid) begin
        ang = clamp(longint'(cfg_start) + longint'(best_pos) * longint'(cfg_step),
                    -64'sd8388608, 64'sd8388607);
        unit_rotation(ang, c, s);
        px = clamp((longint'(best_mm) * c + ROUND_Q30) >>> 30, -64'sd524288, 64'sd524287);
        py = clamp((longint'(best_mm) * s + ROUND_Q30) >>> 30, -64'sd524288, 64'sd524287);
        fix.found    = 1'b1;
        fix.distance = {1'b0, best_mm};
        fix.angle    = ang[23:0];
        fix.pos_x    = px[19:0];
        fix.pos_y    = py[19:0];
      end else begin
        fix.found    = 1'b0;
        fix.distance = NONE_MM;
        fix.angle    = '0;
        fix.pos_x    = NONE_MM;
        fix.pos_y    = '0;
      end
      pending_fixes.push_back(fix);
      scan_pos   = 0;
      best_mm    = 19'h7FFFF;
      best_pos   = 0;
      seen_valid = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_fix();
    out_item_t want;
    if (pending_fixes.size() == 0) begin
      $error("result beat with no scan pending: tdata %h", m_axis_tdata);
      fails++;
    end else begin
      want = pending_fixes.pop_front();
      compare_field("found", longint'(want.found), longint'(m_axis_tuser[0]));
      compare_field("min_distance_mm", longint'(want.distance),
                    longint'($signed(m_axis_tdata[19:0])));
      compare_field("obstacle_angle", longint'(want.angle),
                    longint'($signed(m_axis_tdata[43:20])));
      compare_field("pos_x_mm", longint'(want.pos_x),
                    longint'($signed(m_axis_tdata[63:44])));
      compare_field("pos_y_mm", longint'(want.pos_y),
                    longint'($signed(m_axis_tdata[83:64])));
    end
  endtask

  // Sample beats and result beats at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) absorb_sample($signed(s_axis_tdata[19:0]), s_axis_tuser[0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_fix();
    end
  end

  // Sample driver: advance on an accepted beat, with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        drive_item = sample_q.pop_front();
        s_axis_tdata  <= {4'b0, drive_item.rng};
        s_axis_tuser  <= drive_item.bad;
        s_axis_tlast  <= drive_item.last;
        s_axis_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: long hold-off on request, else random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_RANGE:   cfg_max_mm = val[18:0];
      REG_START_ANGLE: cfg_start  = val;
      REG_ANGLE_STEP:  cfg_step   = val[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_sample(input int rng, input bit bad, input bit last);
    sample_t s;
    s.rng  = 20'(rng);
    s.bad  = bad;
    s.last = last;
    sample_q.push_back(s);
  endtask

  // Wait until every queued sample is taken and every fix has come back
  task automatic settle();
    do @(posedge clk);
    while (sample_q.size() != 0 || s_axis_tvalid || pending_fixes.size() != 0);
    repeat (CORDIC_STEPS + 10) @(posedge clk);
  endtask

  // One random sample; a dud scan holds only invalid ones
  function automatic sample_t draw_sample(input bit dud, input int tie);
    sample_t s;
    int      kind;
    s.bad  = 1'b0;
    s.last = 1'b0;
    kind = dud ? $urandom_range(0, 2) : $urandom_range(0, 15);
    case (kind)
      0: begin
        s.bad = 1'b1;
        s.rng = 20'($urandom);
      end
      1: s.rng = 20'($urandom_range(20'h80000, 20'hFFFFF));
      2: begin
        if (cfg_max_mm != 19'h7FFFF) s.rng = 20'($urandom_range(cfg_max_mm + 1, 524287));
        else s.rng = 20'($urandom_range(20'h80000, 20'hFFFFF));
      end
      3: s.rng = {1'b0, cfg_max_mm};
      4: s.rng = '0;
      5: s.rng = 20'($urandom);
      6, 7: s.rng = 20'(tie);
      default: s.rng = 20'($urandom_range(0, cfg_max_mm));
    endcase
    return s;
  endfunction

  // Queue whole scans of random content; optionally leave one scan open
  task automatic queue_scans(input int n_items, input int max_len, input bit leave_open);
    int      made, len, tie, j;
    bit      dud;
    sample_t s;
    made = 0;
    while (made < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_len)
                                        : $urandom_range(1, max_len);
      dud = ($urandom_range(0, 9) == 0);
      tie = $urandom_range(0, cfg_max_mm);
      for (j = 0; j < len; j++) begin
        s = draw_sample(dud, tie);
        s.last = (j == len - 1);
        sample_q.push_back(s);
      end
      made += len;
    end
    if (leave_open) begin
      len = $urandom_range(1, 4);
      for (j = 0; j < len; j++) begin
        s = draw_sample(1'b0, $urandom_range(0, cfg_max_mm));
        sample_q.push_back(s);
      end
    end
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed scans under the reset settings
    push_sample(0, 0, 1);
    push_sample(500, 0, 0);
    push_sample(300, 0, 0);
    push_sample(300, 0, 0);
    push_sample(30000, 0, 0);
    push_sample(30001, 0, 0);
    push_sample(-1, 0, 0);
    push_sample(100, 1, 0);
    push_sample(700, 0, 1);
    push_sample(-524288, 0, 0);
    push_sample(524287, 0, 0);
    push_sample(5, 1, 0);
    push_sample(30001, 0, 1);
    // leave a scan open across a register write
    push_sample(800, 0, 0);
    push_sample(200, 0, 0);
    settle();
    write_reg(REG_MAX_RANGE, 24'd100);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    push_sample(150, 0, 0);
    push_sample(50, 0, 1);
    settle();
    // saturated angle and the largest accepted range
    write_reg(REG_MAX_RANGE, 24'd524287);
    write_reg(REG_START_ANGLE, 24'h7FFFFF);
    write_reg(REG_ANGLE_STEP, 24'd1048576);
    push_sample(-5, 0, 0);
    push_sample(524287, 0, 1);
    settle();

    // Random scans under a spread of settings, extremes first
    write_reg(REG_MAX_RANGE, 24'd30000);
    write_reg(REG_START_ANGLE, 24'(-3294199));
    write_reg(REG_ANGLE_STEP, 24'd1830);
    queue_scans(120, 10, 1'b0);
    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_MAX_RANGE, 24'd0);
          write_reg(REG_START_ANGLE, 24'h800000);
          write_reg(REG_ANGLE_STEP, 24'd0);
        end
        1: begin
          write_reg(REG_MAX_RANGE, 24'd524287);
          write_reg(REG_START_ANGLE, 24'h7FFFFF);
          write_reg(REG_ANGLE_STEP, 24'd1048576);
        end
        default: begin
          if ($urandom_range(0, 2) != 0)
            write_reg(REG_MAX_RANGE, 24'($urandom_range(0, 1) ? $urandom_range(0, 524287)
                                                              : $urandom_range(0, 3000)));
          if ($urandom_range(0, 2) != 0) write_reg(REG_START_ANGLE, 24'($urandom));
          if ($urandom_range(0, 2) != 0)
            write_reg(REG_ANGLE_STEP, 24'($urandom_range(0, 1) ? $urandom_range(0, 1048576)
                                                               : $urandom_range(0, 5000)));
        end
      endcase
      idle_on = (p != 2);
      queue_scans(85, 10, (p % 3) == 1);
    end

    // Hold off the receiver while short scans keep coming
    settle();
    idle_on = 1'b1;
    hold_req = 1'b1;
    queue_scans(30, 3, 1'b0);

    // Closing stretch without idling
    settle();
    write_reg(REG_ANGLE_STEP, 24'd1830);
    idle_on = 1'b0;
    queue_scans(70, 10, 1'b0);
    settle();
    repeat (CORDIC_STEPS + 20) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
